[hdl/keypad_scan_override_autorepeat_assert.svh]
// Assertion macros for the keypad scanner block.
// Used by the top level; expects clk and rst_n in scope.
`ifndef KEYPAD_SCAN_OVERRIDE_AUTOREPEAT_ASSERT_SVH
`define KEYPAD_SCAN_OVERRIDE_AUTOREPEAT_ASSERT_SVH
`ifndef SYNTHESIS
`define KPSA_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("kpsa assertion failed");
`define KPSA_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kpsa assertion failed");
`else
`define KPSA_ASSERT(label, prop)
`define KPSA_ASSERT_IMP(label, ante, cons)
`endif
`endif

[hdl/kpsa_pkg.sv]
// Package for the keypad scanner: key table, status masks, codes and types.
// No dependencies; used by every module of the block.
package kpsa_pkg;

    localparam int TABLE_LEN     = 13;
    localparam int KEY_COUNT_DEF = 13;
    localparam int KEY_W         = 4;
    localparam int WORD_W        = 32;
    localparam int CFG_W         = 16;
    localparam int CFG_IDX_W     = 2;

    localparam logic [WORD_W-1:0] OVR_MASK_A  = 32'h0000_000C;
    localparam logic [WORD_W-1:0] OVR_MASK_C  = 32'h0000_0BFD;
    localparam logic [WORD_W-1:0] SD_LOCK_BIT = 32'h0002_0000;
    localparam logic [WORD_W-1:0] USB_BIT     = 32'h0008_0000;

    localparam logic [CFG_W-1:0] FIRST_DELAY_RST = 16'd500;
    localparam logic [CFG_W-1:0] PERIOD_RST      = 16'd175;

    // 1 where the key lives in word c, 0 for word a
    localparam logic [TABLE_LEN-1:0] KEY_IN_C = 13'b1_1111_1111_1100;

    localparam logic [WORD_W-1:0] KEY_BITS [TABLE_LEN] = '{
        32'h004, 32'h008, 32'h800, 32'h080, 32'h040, 32'h010, 32'h020,
        32'h300, 32'h200, 32'h100, 32'h004, 32'h008, 32'h001
    };

    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_PRESS,
        CMD_RELEASE,
        CMD_RELEASE_ALL
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIRST_DELAY,
        CFG_PERIOD,
        CFG_REMOTE,
        CFG_SPARE
    } cfg_idx_t;

    typedef struct packed {
        logic [TABLE_LEN-1:0] down;
        logic [KEY_W-1:0]     pressed;
        logic [KEY_W-1:0]     clicked;
    } keys_t;

    function automatic int active_keys(input int key_count);
        active_keys = (key_count < TABLE_LEN) ? key_count : TABLE_LEN;
    endfunction

endpackage

[hdl/kpsa_key_scan.sv]
// Key table decode: pressed vector, first pressed key, first newly pressed key.
// Depends on kpsa_pkg.
module kpsa_key_scan #(
    parameter int KEY_COUNT = kpsa_pkg::KEY_COUNT_DEF
) (
    input  logic [kpsa_pkg::WORD_W-1:0] raw_a,
    input  logic [kpsa_pkg::WORD_W-1:0] raw_c,
    input  logic [kpsa_pkg::WORD_W-1:0] last_a,
    input  logic [kpsa_pkg::WORD_W-1:0] last_c,
    output kpsa_pkg::keys_t             keys
);

    localparam int ACTIVE = kpsa_pkg::active_keys(KEY_COUNT);

    logic [kpsa_pkg::TABLE_LEN-1:0] down_now;
    logic [kpsa_pkg::TABLE_LEN-1:0] down_last;

    always_comb
    begin
        for (int i = 0; i < kpsa_pkg::TABLE_LEN; i++)
        begin
            down_now[i]  = (i < ACTIVE) &&
                (((kpsa_pkg::KEY_IN_C[i] ? raw_c : raw_a) & kpsa_pkg::KEY_BITS[i]) == '0);
            down_last[i] = (i < ACTIVE) &&
                (((kpsa_pkg::KEY_IN_C[i] ? last_c : last_a) & kpsa_pkg::KEY_BITS[i]) == '0);
        end
    end

    // lowest index wins: scan from the top down
    always_comb
    begin
        keys.down    = down_now;
        keys.pressed = '0;
        keys.clicked = '0;
        for (int i = kpsa_pkg::TABLE_LEN - 1; i >= 0; i--)
        begin
            if (down_now[i])
            begin
                keys.pressed = kpsa_pkg::KEY_W'(i + 1);
            end
            if (down_now[i] && !down_last[i])
            begin
                keys.clicked = kpsa_pkg::KEY_W'(i + 1);
            end
        end
    end

endmodule

[hdl/kpsa_repeat.sv]
// Autorepeat tracker: held key, hold start time and first/later repeat phase.
// Depends on kpsa_pkg.
module kpsa_repeat #(
    parameter int KEY_COUNT = kpsa_pkg::KEY_COUNT_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        advance,
    input  logic                        clear_repeat,
    input  logic [kpsa_pkg::WORD_W-1:0] now_ms,
    input  kpsa_pkg::keys_t             keys,
    input  logic [kpsa_pkg::CFG_W-1:0]  first_delay,
    input  logic [kpsa_pkg::CFG_W-1:0]  period,
    output logic [kpsa_pkg::KEY_W-1:0]  repeat_key
);

    localparam int ACTIVE = kpsa_pkg::active_keys(KEY_COUNT);

    logic [kpsa_pkg::KEY_W-1:0]  held_reg, held_next, held_cur, held_idx;
    logic [kpsa_pkg::WORD_W-1:0] since_reg, since_next, elapsed, limit;
    logic                        repeating_reg, repeating_next;
    logic                        held_ok;

    always_comb
    begin
        held_cur   = clear_repeat ? '0 : held_reg;
        held_idx   = held_cur - kpsa_pkg::KEY_W'(1);
        held_ok    = (held_cur != '0) && (held_cur <= kpsa_pkg::KEY_W'(ACTIVE));
        elapsed    = now_ms - since_reg;
        limit      = {{(kpsa_pkg::WORD_W - kpsa_pkg::CFG_W){1'b0}},
                      (repeating_reg ? period : first_delay)};

        held_next      = held_cur;
        since_next     = since_reg;
        repeating_next = repeating_reg;
        repeat_key     = '0;
        if (keys.clicked != '0)
        begin
            held_next      = keys.clicked;
            repeating_next = 1'b0;
            since_next     = now_ms;
            repeat_key     = keys.clicked;
        end
        else if (held_ok && keys.down[held_idx])
        begin
            // wrapped difference read as signed: negative never fires
            if (!elapsed[kpsa_pkg::WORD_W-1] && (elapsed > limit))
            begin
                repeating_next = 1'b1;
                since_next     = now_ms;
                repeat_key     = held_cur;
            end
        end
        else
        begin
            held_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg      <= '0;
            since_reg     <= '0;
            repeating_reg <= 1'b0;
        end
        else if (advance)
        begin
            held_reg      <= held_next;
            since_reg     <= since_next;
            repeating_reg <= repeating_next;
        end
    end

endmodule

[hdl/kpsa_usb.sv]
// USB power pulse meter: saturating run length and last finished pulse.
// Depends on kpsa_pkg.
module kpsa_usb (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       advance,
    input  logic                       level,
    input  logic                       usb_read,
    output logic [kpsa_pkg::CFG_W-1:0] pulse_len
);

    logic [kpsa_pkg::CFG_W-1:0] run_reg, run_next;
    logic [kpsa_pkg::CFG_W-1:0] pulse_reg, pulse_next;

    always_comb
    begin
        run_next  = run_reg;
        pulse_len = pulse_reg;
        if (level)
        begin
            if (run_reg != '1)
            begin
                run_next = run_reg + kpsa_pkg::CFG_W'(1);
            end
        end
        else if (run_reg != '0)
        begin
            pulse_len = run_reg;
            run_next  = '0;
        end
        // reported value is taken before the read clears it
        pulse_next = usb_read ? '0 : pulse_len;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= '0;
            pulse_reg <= '0;
        end
        else if (advance)
        begin
            run_reg   <= run_next;
            pulse_reg <= pulse_next;
        end
    end

endmodule

[hdl/keypad_scan_override_autorepeat.sv]
// Channel | handshake             | payload
// in      | in_valid / in_ready   | raw_word_a/b/c, now_ms, override_on, cmd,
//         |                       | override_key, clear_repeat, usb_read
// out     | out_valid / out_ready | status_a/b/c, pressed_key, clicked_key,
//         |                       | repeat_key, usb_level, usb_pulse_len
// cfg     | cfg_we                | cfg_index, cfg_data
//
// One scan per cycle while out_ready is high; stages: input register, result register.
// All scan state updates in the single cycle a scan moves from input to result register.
// Reset clears override mask and previous words to all ones, repeat and USB state to zero.
// A stalled result holds; the input register still takes one more scan behind it.
// Top level; depends on kpsa_pkg, kpsa_key_scan, kpsa_repeat, kpsa_usb.
module keypad_scan_override_autorepeat #(
    parameter int KEY_COUNT = kpsa_pkg::KEY_COUNT_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [kpsa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [kpsa_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [kpsa_pkg::WORD_W-1:0]    raw_word_a,
    input  logic [kpsa_pkg::WORD_W-1:0]    raw_word_b,
    input  logic [kpsa_pkg::WORD_W-1:0]    raw_word_c,
    input  logic [kpsa_pkg::WORD_W-1:0]    now_ms,
    input  logic                           override_on,
    input  logic [1:0]                     cmd,
    input  logic [kpsa_pkg::KEY_W-1:0]     override_key,
    input  logic                           clear_repeat,
    input  logic                           usb_read,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [kpsa_pkg::WORD_W-1:0]    status_a,
    output logic [kpsa_pkg::WORD_W-1:0]    status_b,
    output logic [kpsa_pkg::WORD_W-1:0]    status_c,
    output logic [kpsa_pkg::KEY_W-1:0]     pressed_key,
    output logic [kpsa_pkg::KEY_W-1:0]     clicked_key,
    output logic [kpsa_pkg::KEY_W-1:0]     repeat_key,
    output logic                           usb_level,
    output logic [kpsa_pkg::CFG_W-1:0]     usb_pulse_len
);

`include "keypad_scan_override_autorepeat_assert.svh"

    localparam int ACTIVE = kpsa_pkg::active_keys(KEY_COUNT);

    // configuration
    logic [kpsa_pkg::CFG_W-1:0] first_delay_reg, period_reg;
    logic                       remote_reg;

    // input register
    logic                        in_vld_reg;
    logic [kpsa_pkg::WORD_W-1:0] raw_a_reg, raw_b_reg, raw_c_reg, now_reg;
    logic                        ovr_on_reg, clear_rep_reg, usb_read_reg;
    kpsa_pkg::cmd_t              cmd_reg;
    logic [kpsa_pkg::KEY_W-1:0]  okey_reg;

    // scan state
    logic [kpsa_pkg::WORD_W-1:0] last_a_reg, last_c_reg;
    logic [kpsa_pkg::WORD_W-1:0] mask_a_reg, mask_a_next, mask_c_reg, mask_c_next;

    // result register
    logic                        out_vld_reg;
    logic [kpsa_pkg::WORD_W-1:0] st_a_reg, st_b_reg, st_c_reg;
    logic [kpsa_pkg::KEY_W-1:0]  pressed_reg, clicked_reg, rep_reg;
    logic                        level_reg;
    logic [kpsa_pkg::CFG_W-1:0]  pulse_reg;

    logic                        advance;
    logic                        okey_valid;
    logic [kpsa_pkg::KEY_W-1:0]  okey_idx;
    logic [kpsa_pkg::WORD_W-1:0] st_a, st_c, st_c_out;
    logic                        level;
    kpsa_pkg::keys_t             keys;
    logic [kpsa_pkg::KEY_W-1:0]  rep_key;
    logic [kpsa_pkg::CFG_W-1:0]  pulse_len;

    assign advance  = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_delay_reg <= kpsa_pkg::FIRST_DELAY_RST;
            period_reg      <= kpsa_pkg::PERIOD_RST;
            remote_reg      <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (kpsa_pkg::cfg_idx_t'(cfg_index))
                kpsa_pkg::CFG_FIRST_DELAY: first_delay_reg <= cfg_data;
                kpsa_pkg::CFG_PERIOD:      period_reg      <= cfg_data;
                kpsa_pkg::CFG_REMOTE:      remote_reg      <= cfg_data[0];
                default:                   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            raw_a_reg     <= raw_word_a;
            raw_b_reg     <= raw_word_b;
            raw_c_reg     <= raw_word_c;
            now_reg       <= now_ms;
            ovr_on_reg    <= override_on;
            cmd_reg       <= kpsa_pkg::cmd_t'(cmd);
            okey_reg      <= override_key;
            clear_rep_reg <= clear_repeat;
            usb_read_reg  <= usb_read;
        end
    end

    // override mask update, applied before this scan's merge
    always_comb
    begin
        okey_valid  = (okey_reg != '0) && (okey_reg <= kpsa_pkg::KEY_W'(ACTIVE));
        okey_idx    = okey_reg - kpsa_pkg::KEY_W'(1);
        mask_a_next = mask_a_reg;
        mask_c_next = mask_c_reg;
        case (cmd_reg)
            kpsa_pkg::CMD_RELEASE_ALL:
            begin
                mask_a_next = mask_a_reg | kpsa_pkg::OVR_MASK_A;
                mask_c_next = mask_c_reg | kpsa_pkg::OVR_MASK_C;
            end
            kpsa_pkg::CMD_PRESS:
            begin
                if (okey_valid)
                begin
                    if (kpsa_pkg::KEY_IN_C[okey_idx])
                        mask_c_next = mask_c_reg & ~kpsa_pkg::KEY_BITS[okey_idx];
                    else
                        mask_a_next = mask_a_reg & ~kpsa_pkg::KEY_BITS[okey_idx];
                end
            end
            kpsa_pkg::CMD_RELEASE:
            begin
                if (okey_valid)
                begin
                    if (kpsa_pkg::KEY_IN_C[okey_idx])
                        mask_c_next = mask_c_reg | kpsa_pkg::KEY_BITS[okey_idx];
                    else
                        mask_a_next = mask_a_reg | kpsa_pkg::KEY_BITS[okey_idx];
                end
            end
            default: ;
        endcase
    end

    always_comb
    begin
        st_a = raw_a_reg;
        st_c = raw_c_reg;
        if (ovr_on_reg)
        begin
            st_a = (raw_a_reg & ~kpsa_pkg::OVR_MASK_A) | (mask_a_next & kpsa_pkg::OVR_MASK_A);
            st_c = (raw_c_reg & ~kpsa_pkg::OVR_MASK_C) | (mask_c_next & kpsa_pkg::OVR_MASK_C);
        end
        level    = |(st_c & kpsa_pkg::USB_BIT);
        st_c_out = st_c & ~kpsa_pkg::SD_LOCK_BIT &
                   ~(remote_reg ? kpsa_pkg::USB_BIT : '0);
    end

    kpsa_key_scan #(
        .KEY_COUNT (KEY_COUNT)
    ) u_key_scan (
        .raw_a  (raw_a_reg),
        .raw_c  (raw_c_reg),
        .last_a (last_a_reg),
        .last_c (last_c_reg),
        .keys   (keys)
    );

    kpsa_repeat #(
        .KEY_COUNT (KEY_COUNT)
    ) u_repeat (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .clear_repeat (clear_rep_reg),
        .now_ms       (now_reg),
        .keys         (keys),
        .first_delay  (first_delay_reg),
        .period       (period_reg),
        .repeat_key   (rep_key)
    );

    kpsa_usb u_usb (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .level     (level),
        .usb_read  (usb_read_reg),
        .pulse_len (pulse_len)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_a_reg <= '1;
            last_c_reg <= '1;
            mask_a_reg <= '1;
            mask_c_reg <= '1;
        end
        else if (advance)
        begin
            last_a_reg <= raw_a_reg;
            last_c_reg <= raw_c_reg;
            mask_a_reg <= mask_a_next;
            mask_c_reg <= mask_c_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            st_a_reg    <= st_a;
            st_b_reg    <= raw_b_reg;
            st_c_reg    <= st_c_out;
            pressed_reg <= keys.pressed;
            clicked_reg <= keys.clicked;
            rep_reg     <= rep_key;
            level_reg   <= level;
            pulse_reg   <= pulse_len;
        end
    end

    assign out_valid     = out_vld_reg;
    assign status_a      = st_a_reg;
    assign status_b      = st_b_reg;
    assign status_c      = st_c_reg;
    assign pressed_key   = pressed_reg;
    assign clicked_key   = clicked_reg;
    assign repeat_key    = rep_reg;
    assign usb_level     = level_reg;
    assign usb_pulse_len = pulse_reg;

    `KPSA_ASSERT_IMP(a_full_when_blocked, !in_ready, in_vld_reg && out_vld_reg && !out_ready)
    `KPSA_ASSERT_IMP(a_click_repeats, out_vld_reg && (clicked_reg != '0), rep_reg == clicked_reg)
    `KPSA_ASSERT_IMP(a_click_after_press, out_vld_reg && (clicked_reg != '0),
        (pressed_reg != '0) && (pressed_reg <= clicked_reg))
    `KPSA_ASSERT_IMP(a_sd_lock_clear, out_vld_reg, (st_c_reg & kpsa_pkg::SD_LOCK_BIT) == '0)

endmodule
